// ===== design/bus_node_liveness_tracker_core_assert.svh =====
// Assertion macros used by the tracker core module.
`ifndef BUS_NODE_LIVENESS_TRACKER_CORE_ASSERT_SVH
`define BUS_NODE_LIVENESS_TRACKER_CORE_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define BNLT_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define BNLT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== design/bnlt_pkg.sv =====
package bnlt_pkg;
    localparam logic [1:0] ST_OFFLINE   = 2'd0;
    localparam logic [1:0] ST_SIMULATED = 2'd1;
    localparam logic [1:0] ST_STARTING  = 2'd2;
    localparam logic [1:0] ST_ONLINE    = 2'd3;

    localparam logic [1:0] MODE_MSG    = 2'd0;
    localparam logic [1:0] MODE_TICK   = 2'd1;
    localparam logic [1:0] MODE_ADD    = 2'd2;
    localparam logic [1:0] MODE_REMOVE = 2'd3;

    localparam logic [2:0] STS_OK         = 3'd0;
    localparam logic [2:0] STS_DONGLELESS = 3'd1;
    localparam logic [2:0] STS_UNKNOWN    = 3'd2;
    localparam logic [2:0] STS_RESERVED   = 3'd3;
    localparam logic [2:0] STS_DUPLICATE  = 3'd4;
    localparam logic [2:0] STS_ABSENT     = 3'd5;
    localparam logic [2:0] STS_FULL       = 3'd6;
    localparam logic [2:0] STS_ECHO       = 3'd7;

    localparam logic [8:0] RESERVED_NODE = 9'd511;
    localparam logic [9:0] MSG_SYSMON_1  = 10'h120;
    localparam logic [9:0] MSG_SET_TIME  = 10'h001;
    localparam logic [5:0] COUNT_MAX     = 6'd63;

    localparam logic [1:0] REG_SIM_OFFLINE = 2'd0;
    localparam logic [1:0] REG_ON_TIMEOUT  = 2'd1;
    localparam logic [1:0] REG_ST_TIMEOUT  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_WAIT, S_DONE, S_OUT
    } fsm_t;

    typedef struct packed {
        logic [7:0] api;
        logic [8:0] node;
        logic [1:0] state;
        logic [31:0] last_rx;
    } ent_t;
endpackage

// ===== design/bnlt_mem.sv =====
module bnlt_mem
    import bnlt_pkg::*;
#(
    parameter int DEVICES = 32,
    parameter int AW = 5
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  ent_t          wdata,
    input  logic [AW-1:0] raddr,
    output ent_t          rdata
);
    ent_t mem [DEVICES];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== design/bus_node_liveness_tracker_core.sv =====
// After an item is accepted, the result is offered once the entry memory has been
// scanned serially (a read per entry), followed by a drain step and an update step.
// Throughput: one item at a time; the next item is taken only after the previous
// result has left, since input reopens only then. No clearing pass runs at reset.
// Ticks take the same time as messages, adds and removes.
// Reset (aresetn low, synchronous) clears valid bits and counters and presets config.
`include "bus_node_liveness_tracker_core_assert.svh"
module bus_node_liveness_tracker_core
    import bnlt_pkg::*;
#(
    parameter int DEVICES = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // mode
    input  logic [1:0]  s_tuser,
    // api_id, node_id, msg_id, to_host, app_mode, is_simulated, time_ms, pad
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status, dev_state, online_count, offline_count, unknown_count, dongleless_count, pad
    output logic [87:0] m_tdata
);
    localparam int AW = (DEVICES > 1) ? $clog2(DEVICES) : 1;
    localparam int CW = $clog2(DEVICES + 1);
    localparam logic [5:0] CNT_CAP = (DEVICES > 63) ? COUNT_MAX : 6'(DEVICES);

    logic        sim_off_reg;
    logic [15:0] on_to_reg, st_to_reg;
    fsm_t        fsm_reg, fsm_next;
    logic [61:0] in_reg;
    logic [1:0]  mode_reg;
    logic [CW-1:0] idx_reg;
    logic [DEVICES-1:0] valid_reg;
    logic        hit_reg, free_reg;
    logic [AW-1:0] hit_idx_reg, free_idx_reg;
    logic [5:0]  on_cnt_reg, off_cnt_reg, on_tot_reg, off_tot_reg;
    logic [31:0] unk_reg, dng_reg;
    logic        rd_v_reg;
    logic [AW-1:0] rd_idx_reg;
    logic [2:0]  sts_reg;
    logic [1:0]  dst_reg;

    logic [1:0]  mode;
    logic [7:0]  api;
    logic [8:0]  node;
    logic [9:0]  mid;
    logic        host, app, sim;
    logic [31:0] now;
    assign mode = mode_reg;
    assign api  = in_reg[7:0];
    assign node = in_reg[16:8];
    assign mid  = in_reg[26:17];
    assign host = in_reg[27];
    assign app  = in_reg[28];
    assign sim  = in_reg[29];
    assign now  = in_reg[61:30];

    logic          we;
    logic [AW-1:0] waddr, raddr;
    ent_t          wdata, rdata;

    bnlt_mem #(.DEVICES(DEVICES), .AW(AW)) u_mem (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    logic [AW-1:0] idx;
    logic          scan_last;
    logic [1:0]    idle_st;
    assign idx = idx_reg[AW-1:0];
    assign scan_last = (idx_reg == CW'(DEVICES - 1));
    assign idle_st = sim_off_reg ? ST_SIMULATED : ST_OFFLINE;
    assign s_tready = (fsm_reg == S_IDLE);
    assign m_tvalid = (fsm_reg == S_OUT);
    assign m_tdata = {7'd0, dng_reg, unk_reg, off_tot_reg, on_tot_reg, dst_reg, sts_reg};

    // Scan pipeline: read at idx, the entry arrives in the next cycle with rd_idx_reg.
    logic [31:0] silence;
    logic        tmo, rd_live;
    logic [1:0]  new_st;
    assign silence = now - rdata.last_rx;
    assign rd_live = rd_v_reg && valid_reg[rd_idx_reg] && (rdata.node != 9'd0);
    assign tmo = ((rdata.state == ST_ONLINE) && (silence > {16'd0, on_to_reg}))
              || ((rdata.state == ST_STARTING) && (silence > {16'd0, st_to_reg}));
    assign new_st = tmo ? idle_st : rdata.state;

    logic key_match;
    assign key_match = rd_v_reg && valid_reg[rd_idx_reg]
                    && (rdata.api == api) && (rdata.node == node);

    logic msg_hit, add_ok;
    assign msg_hit = (mode == MODE_MSG) && (node != RESERVED_NODE) && host && app && hit_reg;
    assign add_ok = (mode == MODE_ADD) && (node != RESERVED_NODE) && !hit_reg && free_reg;

    logic [1:0] msg_st;
    always_comb begin
        msg_st = rdata.state;
        if (!sim) begin
            if (rdata.state == ST_STARTING) begin
                msg_st = ST_ONLINE;
            end else if (rdata.state == ST_OFFLINE || rdata.state == ST_SIMULATED) begin
                msg_st = (mid == MSG_SYSMON_1) ? ST_STARTING : ST_ONLINE;
            end
        end
    end

    always_comb begin
        fsm_next = fsm_reg;
        we = 1'b0;
        waddr = rd_idx_reg;
        wdata = '{api: rdata.api, node: rdata.node, state: new_st, last_rx: rdata.last_rx};
        raddr = idx;
        case (fsm_reg)
            S_IDLE: if (s_tvalid) fsm_next = S_SCAN;
            S_SCAN: begin
                if (mode == MODE_TICK && rd_live) we = 1'b1;
                if (scan_last) fsm_next = S_WAIT;
            end
            S_WAIT: begin
                // The last entry may be the hit, so its index is taken directly.
                raddr = (key_match && !hit_reg) ? rd_idx_reg : hit_idx_reg;
                if (mode == MODE_TICK && rd_live) we = 1'b1;
                fsm_next = S_DONE;
            end
            S_DONE: begin
                waddr = hit_idx_reg;
                if (msg_hit) begin
                    we = 1'b1;
                    wdata = '{api: api, node: node, state: msg_st, last_rx: now};
                end else if (add_ok) begin
                    we = 1'b1;
                    waddr = free_idx_reg;
                    wdata = '{api: api, node: node, state: idle_st, last_rx: 32'd0};
                end
                fsm_next = S_OUT;
            end
            S_OUT: if (m_tready) fsm_next = S_IDLE;
            default: fsm_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg <= S_IDLE;
            sim_off_reg <= 1'b0;
            on_to_reg <= 16'd1000;
            st_to_reg <= 16'd20000;
            valid_reg <= '0;
            on_tot_reg <= '0;
            off_tot_reg <= '0;
            unk_reg <= '0;
            dng_reg <= '0;
            rd_v_reg <= 1'b0;
        end else begin
            fsm_reg <= fsm_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_SIM_OFFLINE: sim_off_reg <= cfg_wdata[0];
                    REG_ON_TIMEOUT:  on_to_reg <= cfg_wdata;
                    REG_ST_TIMEOUT:  st_to_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            rd_v_reg <= (fsm_reg == S_SCAN);
            rd_idx_reg <= idx;
            case (fsm_reg)
                S_IDLE: begin
                    in_reg <= s_tdata[61:0];
                    mode_reg <= s_tuser;
                    idx_reg <= '0;
                    hit_reg <= 1'b0;
                    free_reg <= 1'b0;
                    hit_idx_reg <= '0;
                    free_idx_reg <= '0;
                    on_cnt_reg <= '0;
                    off_cnt_reg <= '0;
                end
                S_SCAN, S_WAIT: begin
                    if (fsm_reg == S_SCAN) begin
                        idx_reg <= idx_reg + 1'b1;
                        if (!valid_reg[idx] && !free_reg) begin
                            free_reg <= 1'b1;
                            free_idx_reg <= idx;
                        end
                    end
                    if (key_match && !hit_reg) begin
                        hit_reg <= 1'b1;
                        hit_idx_reg <= rd_idx_reg;
                    end
                    if (rd_live) begin
                        if (new_st == ST_ONLINE || new_st == ST_STARTING) begin
                            if (on_cnt_reg != COUNT_MAX) on_cnt_reg <= on_cnt_reg + 1'b1;
                        end else if (off_cnt_reg != COUNT_MAX) begin
                            off_cnt_reg <= off_cnt_reg + 1'b1;
                        end
                    end
                end
                S_DONE: begin
                    sts_reg <= STS_OK;
                    dst_reg <= ST_OFFLINE;
                    case (mode)
                        MODE_MSG: begin
                            if (node == RESERVED_NODE) begin
                                sts_reg <= STS_DONGLELESS;
                                if (dng_reg != '1) dng_reg <= dng_reg + 1'b1;
                            end else if (host && app && hit_reg) begin
                                dst_reg <= msg_st;
                            end else if (!host && mid == MSG_SET_TIME) begin
                                sts_reg <= STS_ECHO;
                            end else begin
                                sts_reg <= STS_UNKNOWN;
                                if (unk_reg != '1) unk_reg <= unk_reg + 1'b1;
                            end
                        end
                        MODE_TICK: begin
                            on_tot_reg <= on_cnt_reg;
                            off_tot_reg <= off_cnt_reg;
                        end
                        MODE_ADD: begin
                            if (node == RESERVED_NODE) begin
                                sts_reg <= STS_RESERVED;
                            end else if (hit_reg) begin
                                sts_reg <= STS_DUPLICATE;
                            end else if (!free_reg) begin
                                sts_reg <= STS_FULL;
                            end else begin
                                valid_reg[free_idx_reg] <= 1'b1;
                                dst_reg <= idle_st;
                            end
                        end
                        default: begin
                            if (!hit_reg) sts_reg <= STS_ABSENT;
                            else valid_reg[hit_idx_reg] <= 1'b0;
                        end
                    endcase
                end
                default: ;
            endcase
        end
    end

    logic cnt_ok;
    assign cnt_ok = (on_tot_reg <= CNT_CAP) && (off_tot_reg <= CNT_CAP);

    `BNLT_ASSERT_IMP(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, !s_tready, "out hold")
    `BNLT_ASSERT_NEXT(a_accept_scan, aclk, aresetn, s_tvalid && s_tready, fsm_reg == S_SCAN, "scan")
    `BNLT_ASSERT_IMP(a_cnt_range, aclk, aresetn, m_tvalid, cnt_ok, "count range")
endmodule

// ===== bench/bus_node_liveness_tracker_core_test.sv =====
module bus_node_liveness_tracker_core_test
    import bnlt_pkg::*;
();

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [1:0]  s_tuser;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;

    bus_node_liveness_tracker_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    localparam int NDEV = 32;

    typedef struct packed {
        logic [31:0] dongleless_count;
        logic [31:0] unknown_count;
        logic [5:0]  offline_count;
        logic [5:0]  online_count;
        logic [1:0]  dev_state;
        logic [2:0]  status;
    } report_t;

    // Shadow of the device table and counters.
    logic        sim_offline_q;
    logic [15:0] on_timeout_q;
    logic [15:0] st_timeout_q;
    logic        tbl_valid [NDEV];
    logic [7:0]  tbl_api [NDEV];
    logic [8:0]  tbl_node [NDEV];
    logic [1:0]  tbl_state [NDEV];
    logic [31:0] tbl_last_rx [NDEV];
    logic [5:0]  online_total;
    logic [5:0]  offline_total;
    logic [31:0] unknown_total;
    logic [31:0] dongleless_total;

    report_t     pending_reports[$];
    int          error_count;
    logic        rx_hold;
    int          long_stall;

    // Pools of keys so that messages and removes mostly hit known devices.
    logic [7:0]  key_api [8];
    logic [8:0]  key_node [8];

    always begin
        aclk = 1'b1; #1;
        aclk = 1'b0; #1;
    end

    initial begin
        #4000000;
        $display("bus_node_liveness_tracker_core regression: fail");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        error_count++;
    endtask

    function automatic int lookup_slot(input logic [7:0] api, input logic [8:0] node);
        for (int k = 0; k < NDEV; k++)
            if (tbl_valid[k] && tbl_api[k] == api && tbl_node[k] == node) return k;
        return -1;
    endfunction

    function automatic logic [1:0] idle_state();
        return sim_offline_q ? ST_SIMULATED : ST_OFFLINE;
    endfunction

    task automatic predict_tracker(input logic [1:0] mode, input logic [7:0] api,
                                   input logic [8:0] node, input logic [9:0] mid,
                                   input logic host, input logic app, input logic sim,
                                   input logic [31:0] now);
        report_t r;
        int k;
        logic [5:0] on_n, off_n;
        logic [31:0] silence;
        r = '0;
        if (mode == MODE_MSG) begin
            if (node == RESERVED_NODE) begin
                if (dongleless_total != 32'hFFFF_FFFF) dongleless_total++;
                r.status = STS_DONGLELESS;
            end else if (host && app) begin
                k = lookup_slot(api, node);
                if (k >= 0) begin
                    tbl_last_rx[k] = now;
                    if (!sim) begin
                        if (tbl_state[k] == ST_STARTING) tbl_state[k] = ST_ONLINE;
                        else if (tbl_state[k] != ST_ONLINE)
                            tbl_state[k] = (mid == MSG_SYSMON_1) ? ST_STARTING : ST_ONLINE;
                    end
                    r.dev_state = tbl_state[k];
                end else begin
                    if (unknown_total != 32'hFFFF_FFFF) unknown_total++;
                    r.status = STS_UNKNOWN;
                end
            end else if (!host && mid == MSG_SET_TIME) begin
                r.status = STS_ECHO;
            end else begin
                if (unknown_total != 32'hFFFF_FFFF) unknown_total++;
                r.status = STS_UNKNOWN;
            end
        end else if (mode == MODE_TICK) begin
            on_n = '0;
            off_n = '0;
            for (int j = 0; j < NDEV; j++) begin
                if (!tbl_valid[j] || tbl_node[j] == 0) continue;
                silence = now - tbl_last_rx[j];
                if ((tbl_state[j] == ST_ONLINE && silence > {16'd0, on_timeout_q}) ||
                    (tbl_state[j] == ST_STARTING && silence > {16'd0, st_timeout_q}))
                    tbl_state[j] = idle_state();
                if (tbl_state[j] == ST_ONLINE || tbl_state[j] == ST_STARTING) begin
                    if (on_n < COUNT_MAX) on_n++;
                end else if (off_n < COUNT_MAX) off_n++;
            end
            online_total = on_n;
            offline_total = off_n;
        end else if (mode == MODE_ADD) begin
            if (node == RESERVED_NODE) r.status = STS_RESERVED;
            else if (lookup_slot(api, node) >= 0) r.status = STS_DUPLICATE;
            else begin
                k = -1;
                for (int j = NDEV - 1; j >= 0; j--) if (!tbl_valid[j]) k = j;
                if (k < 0) r.status = STS_FULL;
                else begin
                    tbl_valid[k] = 1'b1;
                    tbl_api[k] = api;
                    tbl_node[k] = node;
                    tbl_last_rx[k] = '0;
                    tbl_state[k] = idle_state();
                    r.dev_state = tbl_state[k];
                end
            end
        end else begin
            k = lookup_slot(api, node);
            if (k < 0) r.status = STS_ABSENT;
            else tbl_valid[k] = 1'b0;
        end
        r.online_count = online_total;
        r.offline_count = offline_total;
        r.unknown_count = unknown_total;
        r.dongleless_count = dongleless_total;
        pending_reports = {pending_reports, r};
    endtask

    task automatic random_gap();
        int g;
        g = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) g = 0;
        repeat (g) @(negedge aclk);
    endtask

    task automatic send_item(input logic [1:0] mode, input logic [7:0] api,
                             input logic [8:0] node, input logic [9:0] mid,
                             input logic host, input logic app, input logic sim,
                             input logic [31:0] now);
        s_tuser = mode;
        s_tdata = {2'd0, now, sim, app, host, mid, node, api};
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_tracker(mode, api, node, mid, host, app, sim, now);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic drain_results();
        while (pending_reports.size() != 0) @(negedge aclk);
        repeat (NDEV + 10) @(negedge aclk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [15:0] val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_we = 1'b0;
        if (idx == REG_SIM_OFFLINE) sim_offline_q = val[0];
        else if (idx == REG_ON_TIMEOUT) on_timeout_q = val;
        else st_timeout_q = val;
    endtask

    always @(posedge aclk) begin
        report_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[80:0];
            if (pending_reports.size() == 0) begin
                report_mismatch("unexpected item", 32'(got.status), 32'd0);
            end else begin
                want = pending_reports.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
                if (got.dev_state !== want.dev_state)
                    report_mismatch("dev_state", 32'(got.dev_state), 32'(want.dev_state));
                if (got.online_count !== want.online_count)
                    report_mismatch("online_count", 32'(got.online_count),
                                    32'(want.online_count));
                if (got.offline_count !== want.offline_count)
                    report_mismatch("offline_count", 32'(got.offline_count),
                                    32'(want.offline_count));
                if (got.unknown_count !== want.unknown_count)
                    report_mismatch("unknown_count", got.unknown_count, want.unknown_count);
                if (got.dongleless_count !== want.dongleless_count)
                    report_mismatch("dongleless_count", got.dongleless_count,
                                    want.dongleless_count);
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    always @(negedge aclk) begin
        if (rx_hold) begin
            m_tready <= 1'b0;
        end else if (long_stall > 0) begin
            m_tready <= 1'b0;
            long_stall <= long_stall - 1;
        end else if ($urandom_range(0, 30) == 0) begin
            long_stall <= $urandom_range(10, 40);
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic test_directed();
        // Extremes of the key fields, reserved node, duplicate, absent, echo.
        send_item(MODE_ADD, 8'd0, 9'd0, 10'd0, 0, 0, 0, 0);
        send_item(MODE_ADD, 8'hFF, 9'd510, 10'h3FF, 1, 1, 1, 32'hFFFF_FFFF);
        send_item(MODE_ADD, 8'd5, RESERVED_NODE, 10'd0, 0, 0, 0, 0);
        send_item(MODE_ADD, 8'hFF, 9'd510, 10'd0, 0, 0, 0, 0);
        send_item(MODE_REMOVE, 8'd7, 9'd7, 10'd0, 0, 0, 0, 0);
        send_item(MODE_MSG, 8'hFF, 9'd510, MSG_SYSMON_1, 1, 1, 0, 32'd100);
        send_item(MODE_MSG, 8'hFF, 9'd510, 10'd3, 1, 1, 0, 32'd200);
        send_item(MODE_MSG, 8'd0, 9'd0, 10'd3, 1, 1, 0, 32'd300);
        send_item(MODE_MSG, 8'd0, 9'd0, 10'd3, 1, 1, 1, 32'd350);
        send_item(MODE_MSG, 8'd1, RESERVED_NODE, 10'd3, 1, 1, 0, 32'd0);
        send_item(MODE_MSG, 8'd9, 9'd9, 10'd3, 1, 1, 0, 32'd0);
        send_item(MODE_MSG, 8'd0, 9'd0, MSG_SET_TIME, 0, 1, 0, 32'd0);
        send_item(MODE_MSG, 8'd0, 9'd0, 10'd4, 0, 0, 0, 32'd0);
        send_item(MODE_MSG, 8'd0, 9'd0, MSG_SET_TIME, 1, 0, 0, 32'd0);
        send_item(MODE_TICK, 8'd0, 9'd0, 10'd0, 0, 0, 0, 32'd500);
        send_item(MODE_TICK, 8'd0, 9'd0, 10'd0, 0, 0, 0, 32'd5000);
        send_item(MODE_TICK, 8'd0, 9'd0, 10'd0, 0, 0, 0, 32'd150);
        send_item(MODE_REMOVE, 8'hFF, 9'd510, 10'd0, 0, 0, 0, 0);
        send_item(MODE_REMOVE, 8'd0, 9'd0, 10'd0, 0, 0, 0, 0);
        drain_results();
    endtask

    task automatic test_table_full();
        for (int i = 0; i < NDEV + 2; i++)
            send_item(MODE_ADD, i[7:0], 9'd100 + i[8:0], 10'd0, 0, 0, 0, 0);
        send_item(MODE_TICK, 8'd0, 9'd0, 10'd0, 0, 0, 0, 32'd1);
        for (int i = 0; i < NDEV + 2; i++)
            send_item(MODE_REMOVE, i[7:0], 9'd100 + i[8:0], 10'd0, 0, 0, 0, 0);
        drain_results();
    endtask

    task automatic test_random(input int count);
        logic [1:0] mode;
        logic [7:0] api;
        logic [8:0] node;
        logic [9:0] mid;
        logic host, app, sim;
        logic [31:0] now;
        int r, p;
        now = $urandom;
        for (int i = 0; i < NDEV / 4; i++) begin
            key_api[i] = 8'($urandom);
            key_node[i] = 9'($urandom_range(0, 510));
        end
        key_node[0] = 9'd0;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            p = $urandom_range(0, 7);
            api = key_api[p];
            node = key_node[p];
            host = 1'b1;
            app = 1'b1;
            sim = ($urandom_range(0, 4) == 0);
            mid = ($urandom_range(0, 2) == 0) ? MSG_SYSMON_1 : 10'($urandom);
            now = now + $urandom_range(0, on_timeout_q / 2 + 200);
            if (r < 55) mode = MODE_MSG;
            else if (r < 70) mode = MODE_TICK;
            else if (r < 82) mode = MODE_ADD;
            else if (r < 90) mode = MODE_REMOVE;
            else begin
                // Noise: mostly random fields, biased toward the reserved node and set-time id.
                mode = 2'($urandom);
                api = 8'($urandom);
                node = ($urandom_range(0, 5) == 0) ? RESERVED_NODE : 9'($urandom);
                mid = ($urandom_range(0, 3) == 0) ? MSG_SET_TIME : 10'($urandom);
                host = 1'($urandom);
                app = 1'($urandom);
                sim = 1'($urandom);
                if ($urandom_range(0, 1)) now = $urandom;
            end
            send_item(mode, api, node, mid, host, app, sim, now);
            random_gap();
        end
        drain_results();
    endtask

    task automatic test_backpressure();
        rx_hold <= 1'b1;
        fork
            begin
                for (int i = 0; i < 6; i++)
                    send_item(MODE_MSG, 8'd3, 9'd3, 10'd3, 0, 0, 0, 0);
            end
            begin
                repeat (400) @(negedge aclk);
                rx_hold <= 1'b0;
            end
        join
        drain_results();
    endtask

    initial begin
        error_count = 0;
        rx_hold = 1'b0;
        long_stall = 0;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_SIM_OFFLINE;
        cfg_wdata = 16'd0;
        s_tvalid = 1'b0;
        s_tuser = MODE_MSG;
        s_tdata = '0;
        m_tready = 1'b0;
        sim_offline_q = 1'b0;
        on_timeout_q = 16'd1000;
        st_timeout_q = 16'd20000;
        for (int k = 0; k < NDEV; k++) begin
            tbl_valid[k] = 1'b0;
            tbl_api[k] = '0;
            tbl_node[k] = '0;
            tbl_state[k] = '0;
            tbl_last_rx[k] = '0;
        end
        online_total = '0;
        offline_total = '0;
        unknown_total = '0;
        dongleless_total = '0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();
        test_table_full();
        test_backpressure();
        test_random(300);
        write_register(REG_SIM_OFFLINE, 16'd1);
        write_register(REG_ON_TIMEOUT, 16'd0);
        write_register(REG_ST_TIMEOUT, 16'd0);
        test_directed();
        test_random(250);
        write_register(REG_ON_TIMEOUT, 16'hFFFF);
        write_register(REG_ST_TIMEOUT, 16'hFFFF);
        test_random(250);
        write_register(REG_SIM_OFFLINE, 16'd0);
        write_register(REG_ON_TIMEOUT, 16'd300);
        write_register(REG_ST_TIMEOUT, 16'd700);
        test_random(250);

        if (error_count == 0)
            $display("bus_node_liveness_tracker_core regression: pass");
        else
            $display("bus_node_liveness_tracker_core regression: fail");
        $finish;
    end
endmodule
